// ===== rtl/gdr_pkg.sv =====
`default_nettype none

package gdr_pkg;

  // Block dimensions.
  localparam int NUM_HEADS = 4;
  localparam int KEY_DIM   = 128;
  localparam int VALUE_DIM = 128;

  localparam int VEC_DEPTH = NUM_HEADS * KEY_DIM;
  localparam int MAT_DEPTH = VEC_DEPTH * VALUE_DIM;

  localparam int VEC_AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int MAT_AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int COL_W  = (KEY_DIM > 1) ? $clog2(KEY_DIM) : 1;
  localparam int CNT_W  = $clog2(KEY_DIM + 1);

  // Field widths of the ports.
  localparam int TYPE_W = 2;
  localparam int HEAD_W = 2;
  localparam int IDX_W  = 7;
  localparam int ELEM_W = 16;
  localparam int WORD_W = 32;

  // Accumulator: 48-bit products summed over KEY_DIM terms.
  localparam int ACC_W = 48 + CNT_W;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ROW   = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_ROW       = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ      = 3'd3,
    OP_READ_ZERO = 3'd4
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VEC_AW-1:0]  vec_addr;
    logic [MAT_AW-1:0]  mat_addr;
    logic [MAT_AW-1:0]  row_base;
    logic [ELEM_W-1:0]  key_elem;
    logic [ELEM_W-1:0]  query_elem;
    logic [ELEM_W-1:0]  gate;
    logic [ELEM_W-1:0]  beta;
    logic [ELEM_W-1:0]  value_elem;
    logic [WORD_W-1:0]  state_word;
    logic               keep;
  } cmd_t;

  // Clamp to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gdr_front.sv =====
`default_nettype none

module gdr_front import gdr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [TYPE_W-1:0]  req_type_i,
  input  wire logic [HEAD_W-1:0]  head_i,
  input  wire logic [IDX_W-1:0]   row_i,
  input  wire logic [IDX_W-1:0]   col_i,
  input  wire logic [ELEM_W-1:0]  key_elem_i,
  input  wire logic [ELEM_W-1:0]  query_elem_i,
  input  wire logic [ELEM_W-1:0]  gate_i,
  input  wire logic [ELEM_W-1:0]  beta_i,
  input  wire logic [ELEM_W-1:0]  value_elem_i,
  input  wire logic [WORD_W-1:0]  state_word_i,
  input  wire logic               keep_update_i,
  input  wire logic               clear_busy_i,
  input  wire logic               pop_i,
  output      logic               cmd_valid_o,
  output      cmd_t               cmd_o
);

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  logic   head_ok, row_ok, col_ok;
  logic   push_ok;
  logic   push;
  cmd_t   cmd_in;

  cmd_t             queue_q [QDEPTH];
  logic [QPW-1:0]   wptr_q, rptr_q;
  logic [QCW-1:0]   cnt_q;

  // Range checks on the indexes.
  assign head_ok = int'(head_i) < NUM_HEADS;
  assign row_ok  = int'(row_i) < VALUE_DIM;
  assign col_ok  = int'(col_i) < KEY_DIM;

  // Classify the item and work out its addresses.
  always_comb begin
    cmd_in            = '0;
    cmd_in.op         = OP_LOAD;
    cmd_in.key_elem   = key_elem_i;
    cmd_in.query_elem = query_elem_i;
    cmd_in.gate       = gate_i;
    cmd_in.beta       = beta_i;
    cmd_in.value_elem = value_elem_i;
    cmd_in.state_word = state_word_i;
    cmd_in.keep       = keep_update_i;
    cmd_in.row_base   = MAT_AW'((int'(head_i) * VALUE_DIM + int'(row_i)) * KEY_DIM);
    cmd_in.mat_addr   = MAT_AW'((int'(head_i) * VALUE_DIM + int'(row_i)) * KEY_DIM
                                + int'(col_i));
    cmd_in.vec_addr   = VEC_AW'(int'(head_i) * KEY_DIM + int'(col_i));
    push_ok           = 1'b0;
    case (req_e'(req_type_i))
      REQ_LOAD: begin
        cmd_in.op = OP_LOAD;
        push_ok   = head_ok && col_ok;
      end
      REQ_ROW: begin
        cmd_in.op       = OP_ROW;
        cmd_in.vec_addr = VEC_AW'(int'(head_i) * KEY_DIM);
        push_ok         = head_ok && row_ok;
      end
      REQ_WRITE: begin
        cmd_in.op = OP_WRITE;
        push_ok   = head_ok && row_ok && col_ok;
      end
      REQ_READ: begin
        cmd_in.op = (head_ok && row_ok && col_ok) ? OP_READ : OP_READ_ZERO;
        push_ok   = 1'b1;
      end
      default: begin
        push_ok = 1'b0;
      end
    endcase
  end

  // Out-of-range load, row and write items are taken and dropped; reads become OP_READ_ZERO.
  assign in_ready_o  = (cnt_q != QCW'(QDEPTH)) && !clear_busy_i;
  assign push        = in_valid_i && in_ready_o && push_ok;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = queue_q[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QPW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gdr_back.sv =====
`default_nettype none

module gdr_back import gdr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               cmd_valid_i,
  input  wire cmd_t               cmd_i,
  output      logic               pop_o,
  output      logic               clear_busy_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [WORD_W-1:0]  result_value_o,
  output      logic               result_kind_o
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_RD    = 10'b00_0000_0100,
    S_P1    = 10'b00_0000_1000,
    S_KV    = 10'b00_0001_0000,
    S_DMUL  = 10'b00_0010_0000,
    S_DSAT  = 10'b00_0100_0000,
    S_P2    = 10'b00_1000_0000,
    S_Y     = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Memories.
  logic [ELEM_W-1:0] key_mem   [VEC_DEPTH];
  logic [ELEM_W-1:0] query_mem [VEC_DEPTH];
  logic [ELEM_W-1:0] kgate_mem [VEC_DEPTH];
  logic [WORD_W-1:0] state_mem [MAT_DEPTH];
  logic [WORD_W-1:0] work_mem  [KEY_DIM];

  logic [ELEM_W-1:0] key_rd_q, query_rd_q, kgate_rd_q;
  logic [WORD_W-1:0] state_rd_q, work_rd_q;

  logic              gate_mode_q;
  cmd_t              cur_q;
  logic [MAT_AW-1:0] clr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pass2_q;
  logic              v1_q, v2_q, v3_q, v4_q;
  logic [COL_W-1:0]  col1_q, col2_q, col3_q;

  logic signed [48:0]       p1_q;
  logic signed [ELEM_W-1:0] k2_q, k3_q;
  logic signed [WORD_W-1:0] w1_q;
  logic signed [WORD_W-1:0] x_q;
  logic signed [47:0]       p2_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [WORD_W-1:0] kv_q, delta_q;
  logic signed [51:0]       dprod_q;
  logic [WORD_W-1:0]        res_q;
  logic                     kind_q;
  logic                     out_valid_q;
  logic [WORD_W-1:0]        out_value_q;
  logic                     out_kind_q;

  logic                     idle_take;
  logic                     issue;
  logic [COL_W-1:0]         col;
  logic [VEC_AW-1:0]        vec_rd_addr;
  logic [MAT_AW-1:0]        mat_rd_addr;
  logic                     mat_rd_en;
  logic                     mat_we;
  logic [MAT_AW-1:0]        mat_wa;
  logic [WORD_W-1:0]        mat_wd;
  logic                     out_free;
  logic                     pipe_empty;
  logic [ELEM_W-1:0]        gate_sel;
  logic signed [WORD_W-1:0] op_a;
  logic signed [16:0]       op_b;
  logic signed [48:0]       r16, r12;
  logic signed [WORD_W-1:0] x_d;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [34:0]       diff;
  logic signed [51:0]       drnd;

  assign idle_take    = (state_q == S_IDLE) && cmd_valid_i;
  assign pop_o        = idle_take;
  assign clear_busy_o = state_q == S_CLEAR;
  assign issue        = ((state_q == S_P1) || (state_q == S_P2)) &&
                        (cnt_q < CNT_W'(KEY_DIM));
  assign col          = cnt_q[COL_W-1:0];
  assign vec_rd_addr  = cur_q.vec_addr + VEC_AW'(col);
  assign mat_rd_addr  = idle_take ? cmd_i.mat_addr : cur_q.row_base + MAT_AW'(col);
  assign mat_rd_en    = (idle_take && (cmd_i.op == OP_READ)) || issue;
  assign out_free     = !out_valid_q || out_ready_i;
  assign pipe_empty   = !v1_q && !v2_q && !v3_q && !v4_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      gate_mode_q <= cfg_wdata_i;
    end
  end

  // Key, query and key-gate stores: written by loads, read during a row.
  always_ff @(posedge clk_i) begin
    if (idle_take && (cmd_i.op == OP_LOAD)) begin
      key_mem[cmd_i.vec_addr]   <= cmd_i.key_elem;
      query_mem[cmd_i.vec_addr] <= cmd_i.query_elem;
      kgate_mem[cmd_i.vec_addr] <= cmd_i.gate;
    end
    if (issue) begin
      key_rd_q   <= key_mem[vec_rd_addr];
      query_rd_q <= query_mem[vec_rd_addr];
      kgate_rd_q <= kgate_mem[vec_rd_addr];
    end
  end

  // State matrix write port: clearing pass, state writes or row write-back.
  always_comb begin
    mat_we = 1'b0;
    mat_wa = cur_q.row_base + MAT_AW'(col3_q);
    mat_wd = x_q;
    if (state_q == S_CLEAR) begin
      mat_we = 1'b1;
      mat_wa = clr_q;
      mat_wd = '0;
    end else if (idle_take && (cmd_i.op == OP_WRITE)) begin
      mat_we = 1'b1;
      mat_wa = cmd_i.mat_addr;
      mat_wd = cmd_i.state_word;
    end else if (v3_q && pass2_q && cur_q.keep) begin
      mat_we = 1'b1;
    end
  end

  // State matrix.
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      state_mem[mat_wa] <= mat_wd;
    end
    if (mat_rd_en) begin
      state_rd_q <= state_mem[mat_rd_addr];
    end
  end

  // Row work buffer: decayed row in the first pass, read back in the second.
  always_ff @(posedge clk_i) begin
    if (v3_q && !pass2_q) begin
      work_mem[col3_q] <= x_q;
    end
    if (issue) begin
      work_rd_q <= work_mem[col];
    end
  end

  // First multiplier: state times gate, or key times delta.
  assign gate_sel = gate_mode_q ? kgate_rd_q : cur_q.gate;
  assign op_a     = pass2_q ? delta_q : $signed(state_rd_q);
  assign op_b     = pass2_q ? $signed({key_rd_q[ELEM_W-1], key_rd_q})
                            : $signed({1'b0, gate_sel});

  // Rounding of the first product, then saturation of the updated element.
  assign r16 = (p1_q + 49'(32768)) >>> 16;
  assign r12 = (p1_q + 49'(2048)) >>> 12;
  assign x_d = pass2_q ? sat32(64'(r12) + 64'(w1_q)) : r16[WORD_W-1:0];

  // Rounded accumulator, and the delta terms.
  assign acc_rnd = (acc_q + ACC_W'(2048)) >>> 12;
  assign diff    = (35'($signed(cur_q.value_elem)) <<< 4) - 35'(kv_q);
  assign drnd    = (dprod_q + 52'(32768)) >>> 16;

  // Element pipeline datapath.
  always_ff @(posedge clk_i) begin
    p1_q   <= 49'(op_a) * 49'(op_b);
    k2_q   <= pass2_q ? $signed(query_rd_q) : $signed(key_rd_q);
    w1_q   <= $signed(work_rd_q);
    col2_q <= col1_q;
    x_q    <= x_d;
    k3_q   <= k2_q;
    col3_q <= col2_q;
    p2_q   <= 48'(x_q) * 48'(k3_q);
    if (issue) begin
      col1_q <= col;
    end
  end

  // Control and per-row registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      pass2_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (idle_take && (cmd_i.op == OP_ROW)) begin
        cnt_q   <= '0;
        pass2_q <= 1'b0;
      end
      if (state_q == S_DSAT) begin
        cnt_q   <= '0;
        pass2_q <= 1'b1;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Row arithmetic and result registers.
  always_ff @(posedge clk_i) begin
    if (idle_take) begin
      cur_q <= cmd_i;
    end
    if ((idle_take && (cmd_i.op == OP_ROW)) || (state_q == S_DSAT)) begin
      acc_q <= '0;
    end else if (v4_q) begin
      acc_q <= acc_q + ACC_W'(p2_q);
    end
    if (state_q == S_KV) begin
      kv_q <= sat32(64'(acc_rnd));
    end
    if (state_q == S_DMUL) begin
      dprod_q <= 52'(diff) * 52'($signed({1'b0, cur_q.beta}));
    end
    if (state_q == S_DSAT) begin
      delta_q <= sat32(64'(drnd));
    end
    if (idle_take && (cmd_i.op == OP_READ_ZERO)) begin
      res_q  <= '0;
      kind_q <= KIND_READ;
    end
    if (state_q == S_RD) begin
      res_q  <= state_rd_q;
      kind_q <= KIND_READ;
    end
    if (state_q == S_Y) begin
      res_q  <= sat32(64'(acc_rnd));
      kind_q <= KIND_ROW;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_value_q <= res_q;
      out_kind_q  <= kind_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == MAT_AW'(MAT_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (idle_take) begin
          case (cmd_i.op)
            OP_ROW:       state_d = S_P1;
            OP_READ:      state_d = S_RD;
            OP_READ_ZERO: state_d = S_OUT;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_P1: begin
        if (!issue && pipe_empty) begin
          state_d = S_KV;
        end
      end
      S_KV: begin
        state_d = S_DMUL;
      end
      S_DMUL: begin
        state_d = S_DSAT;
      end
      S_DSAT: begin
        state_d = S_P2;
      end
      S_P2: begin
        if (!issue && pipe_empty) begin
          state_d = S_Y;
        end
      end
      S_Y: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_kind_o  = out_kind_q;

endmodule

`default_nettype wire

// ===== rtl/gated_delta_rule_recurrence.sv =====
// Gated delta rule recurrence, one state matrix per head, in fixed point.
// Input channel (in_valid_i/in_ready_o) takes load, row, state write and
// state read items; the output channel (out_valid_o/out_ready_i) returns one
// result item for each in-range row item and each read item, in order.
// cfg_we_i/cfg_wdata_i write gate_mode; write it only while the block is idle.
// A front stage classifies items into a two-entry queue; a back sequencer
// executes them one at a time.
// A row item streams the row twice through a five-stage
// multiply-accumulate pipeline on a single state memory port, once for
// decay and key dot product, once for update and query dot product.
// Reset: a clearing pass writes zero to all NUM_HEADS*VALUE_DIM*KEY_DIM state
// words (65536 of them); in_ready_o stays low until it is done.
// When the receiver stalls, the result item is held in the output register
// and the next result waits in the back part; the queue keeps taking items
// until it is full.
`default_nettype none

module gated_delta_rule_recurrence import gdr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [TYPE_W-1:0]  req_type_i,
  input  wire logic [HEAD_W-1:0]  head_i,
  input  wire logic [IDX_W-1:0]   row_i,
  input  wire logic [IDX_W-1:0]   col_i,
  input  wire logic [ELEM_W-1:0]  key_elem_i,
  input  wire logic [ELEM_W-1:0]  query_elem_i,
  input  wire logic [ELEM_W-1:0]  gate_i,
  input  wire logic [ELEM_W-1:0]  beta_i,
  input  wire logic [ELEM_W-1:0]  value_elem_i,
  input  wire logic [WORD_W-1:0]  state_word_i,
  input  wire logic               keep_update_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [WORD_W-1:0]  result_value_o,
  output      logic               result_kind_o
);

  logic clear_busy;
  logic pop;
  logic cmd_valid;
  cmd_t cmd;

  // Front: accepts and classifies items.
  gdr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .head_i        (head_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .key_elem_i    (key_elem_i),
    .query_elem_i  (query_elem_i),
    .gate_i        (gate_i),
    .beta_i        (beta_i),
    .value_elem_i  (value_elem_i),
    .state_word_i  (state_word_i),
    .keep_update_i (keep_update_i),
    .clear_busy_i  (clear_busy),
    .pop_i         (pop),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  // Back: memories and row sequencer.
  gdr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .pop_o          (pop),
    .clear_busy_o   (clear_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .result_kind_o  (result_kind_o)
  );

  // No item enters while the state matrix is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !in_ready_o)
    else $error("item accepted during clearing pass");

  // No result can exist during the clearing pass.
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !out_valid_o)
    else $error("result during clearing pass");

  // The clearing pass runs only once after reset.
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_busy) |=> !clear_busy)
    else $error("clearing pass restarted");

  // Nothing is taken from the queue while clearing.
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !pop)
    else $error("queue popped during clearing pass");

endmodule

`default_nettype wire
